### src/rcbp_pkg.sv
// shared types and byte codes for the remote command byte parser
// no dependencies; imported by every module of the block
package rcbp_pkg;

  localparam int FRAME_MAX_DEF = 64;

  localparam int VALUE_W = 32;

  // byte codes seen on the link
  localparam logic [7:0] BYTE_LINE      = 8'd10;
  localparam logic [7:0] BYTE_GEAR_LOW  = 8'h59;
  localparam logic [7:0] BYTE_GEAR_HIGH = 8'h58;
  localparam logic [7:0] BYTE_STOP      = 8'h5A;
  localparam logic [7:0] BYTE_FWD       = 8'h41;
  localparam logic [7:0] BYTE_RIGHT_LO  = 8'h42;
  localparam logic [7:0] BYTE_RIGHT_HI  = 8'h44;
  localparam logic [7:0] BYTE_BACK      = 8'h45;
  localparam logic [7:0] BYTE_LEFT_LO   = 8'h46;
  localparam logic [7:0] BYTE_LEFT_HI   = 8'h48;
  localparam logic [7:0] BYTE_OPEN      = 8'h7B;
  localparam logic [7:0] BYTE_CLOSE     = 8'h7D;
  localparam logic [7:0] BYTE_UPLOAD    = 8'h50;
  localparam logic [7:0] BYTE_DIGIT0    = 8'h30;
  localparam logic [7:0] BYTE_ID_MAX    = 8'h35;

  typedef logic [2:0] dir_t;

  localparam dir_t DIR_STOP  = 3'd0;
  localparam dir_t DIR_FWD   = 3'd1;
  localparam dir_t DIR_BACK  = 3'd2;
  localparam dir_t DIR_RIGHT = 3'd3;
  localparam dir_t DIR_LEFT  = 3'd4;

  // gain selects that carry a thousandths scale
  localparam logic [2:0] SEL_SPEED_KP = 3'd2;
  localparam logic [2:0] SEL_SPEED_KI = 3'd3;
  localparam logic [2:0] SEL_TURN_KD  = 3'd5;

  typedef struct packed {
    logic                      write;
    logic [2:0]                select;
    logic signed [VALUE_W-1:0] value;
    logic                      thou;
    logic                      upload;
  } frame_res_t;

endpackage

### src/rcbp_drive.sv
// held drive direction and speed gear decoding
// depends on rcbp_pkg
module rcbp_drive (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic [7:0]    rx_byte,
  output rcbp_pkg::dir_t dir_nxt,
  output logic          gear_nxt
);
  import rcbp_pkg::*;

  // binary single-byte commands
  localparam logic [7:0] CODE_FWD      = 8'd1;
  localparam logic [7:0] CODE_RIGHT_LO = 8'd2;
  localparam logic [7:0] CODE_RIGHT_HI = 8'd4;
  localparam logic [7:0] CODE_BACK     = 8'd5;
  localparam logic [7:0] CODE_LEFT_LO  = 8'd6;
  localparam logic [7:0] CODE_LEFT_HI  = 8'd8;

  dir_t dir_r;
  logic gear_r;

  always_comb begin
    if (rx_byte > BYTE_LINE) begin
      case (rx_byte) inside
        BYTE_STOP:                    dir_nxt = DIR_STOP;
        BYTE_FWD:                     dir_nxt = DIR_FWD;
        BYTE_BACK:                    dir_nxt = DIR_BACK;
        [BYTE_RIGHT_LO:BYTE_RIGHT_HI]: dir_nxt = DIR_RIGHT;
        [BYTE_LEFT_LO:BYTE_LEFT_HI]:   dir_nxt = DIR_LEFT;
        default:                      dir_nxt = DIR_STOP;
      endcase
    end else if (rx_byte < BYTE_LINE) begin
      case (rx_byte) inside
        CODE_FWD:                     dir_nxt = DIR_FWD;
        CODE_BACK:                    dir_nxt = DIR_BACK;
        [CODE_RIGHT_LO:CODE_RIGHT_HI]: dir_nxt = DIR_RIGHT;
        [CODE_LEFT_LO:CODE_LEFT_HI]:   dir_nxt = DIR_LEFT;
        default:                      dir_nxt = DIR_STOP;
      endcase
    end else begin
      dir_nxt = dir_r;
    end

    if (rx_byte == BYTE_GEAR_LOW) begin
      gear_nxt = 1'b0;
    end else if (rx_byte == BYTE_GEAR_HIGH) begin
      gear_nxt = 1'b1;
    end else begin
      gear_nxt = gear_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= DIR_STOP;
      gear_r <= 1'b0;
    end else if (adv) begin
      dir_r  <= dir_nxt;
      gear_r <= gear_nxt;
    end
  end

endmodule

### src/rcbp_frame.sv
// parameter frame collector with saturating decimal accumulator
// depends on rcbp_pkg
module rcbp_frame #(
  parameter int FRAME_MAX = rcbp_pkg::FRAME_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic [7:0]           rx_byte,
  output rcbp_pkg::frame_res_t res
);
  import rcbp_pkg::*;

  localparam int POS_W = $clog2(FRAME_MAX + 1);
  localparam int EXT_W = VALUE_W + 5;
  localparam logic signed [EXT_W-1:0] ACC_MAX = EXT_W'(64'sd2147483647);
  localparam logic signed [EXT_W-1:0] ACC_MIN = EXT_W'(-64'sd2147483648);
  localparam logic [POS_W-1:0] POS_ID     = POS_W'(1);
  localparam logic [POS_W-1:0] POS_FOURTH = POS_W'(3);
  localparam logic [POS_W-1:0] POS_LIMIT  = POS_W'(FRAME_MAX);

  logic                      collecting_r, collecting_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic [7:0]                id_r, id_nxt;
  logic [7:0]                fourth_r, fourth_nxt;
  logic signed [VALUE_W-1:0] acc_r, acc_nxt;

  logic signed [EXT_W-1:0] acc_ext;
  logic signed [EXT_W-1:0] digit;
  logic signed [EXT_W-1:0] fold;
  logic [7:0]              id_off;

  // acc*10 as two shifts, then the raw digit offset
  assign acc_ext = EXT_W'(acc_r);
  assign digit   = EXT_W'($signed({1'b0, rx_byte})) - EXT_W'(48);
  assign fold    = (acc_ext <<< 3) + (acc_ext <<< 1) + digit;
  assign id_off  = id_r - BYTE_DIGIT0;

  always_comb begin
    res            = '0;
    collecting_nxt = collecting_r;
    pos_nxt        = pos_r;
    id_nxt         = id_r;
    fourth_nxt     = fourth_r;
    acc_nxt        = acc_r;

    if (rx_byte == BYTE_CLOSE) begin
      if (fourth_r == BYTE_UPLOAD) begin
        res.upload = 1'b1;
      end else if (id_r >= BYTE_DIGIT0 && id_r <= BYTE_ID_MAX) begin
        res.write  = 1'b1;
        res.select = id_off[2:0];
        res.value  = acc_r;
        res.thou   = (id_off[2:0] inside {SEL_SPEED_KP, SEL_SPEED_KI, SEL_TURN_KD});
      end
      collecting_nxt = 1'b0;
      pos_nxt        = '0;
      id_nxt         = '0;
      fourth_nxt     = '0;
      acc_nxt        = '0;
    end else if (collecting_r || rx_byte == BYTE_OPEN) begin
      collecting_nxt = 1'b1;
      if (pos_r < POS_LIMIT) begin
        if (pos_r == POS_ID) begin
          id_nxt = rx_byte;
        end
        if (pos_r == POS_FOURTH) begin
          fourth_nxt = rx_byte;
        end
        if (pos_r >= POS_FOURTH) begin
          if (fold > ACC_MAX) begin
            acc_nxt = ACC_MAX[VALUE_W-1:0];
          end else if (fold < ACC_MIN) begin
            acc_nxt = ACC_MIN[VALUE_W-1:0];
          end else begin
            acc_nxt = fold[VALUE_W-1:0];
          end
        end
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      pos_r        <= '0;
      id_r         <= '0;
      fourth_r     <= '0;
      acc_r        <= '0;
    end else if (adv) begin
      collecting_r <= collecting_nxt;
      pos_r        <= pos_nxt;
      id_r         <= id_nxt;
      fourth_r     <= fourth_nxt;
      acc_r        <= acc_nxt;
    end
  end

endmodule

### src/remote_command_byte_parser.sv
// top level of the remote command byte parser: input register, decode, result register
// depends on rcbp_pkg, rcbp_drive and rcbp_frame
//
// One result beat per input beat, one beat per cycle sustained while out_stall
// is low. A byte goes into the input register, then the drive decoder and the
// frame collector work on it combinationally and the outcome lands in the
// result register. Single bytes set the held direction and gear that every
// result carries. A '{' opens a frame, position 1 is the id and bytes from
// position 3 are folded as acc*10 + (byte - '0') with 32-bit saturation and
// no digit check; bytes at positions FRAME_MAX and beyond are dropped. The
// '}' closing a frame gives either an upload request ('P' at position 3) or
// one parameter write for ids '0' to '5'; ids 2, 3 and 5 are flagged as
// thousandths. The state advances only when a byte moves from the input
// register into the result register, so stalls on the result side never
// disturb it.
module remote_command_byte_parser #(
  parameter int FRAME_MAX = rcbp_pkg::FRAME_MAX_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           out_direction,
  output logic                                 out_high_speed,
  output logic                                 out_param_write,
  output logic [2:0]                           out_param_select,
  output logic signed [rcbp_pkg::VALUE_W-1:0]  out_param_value,
  output logic                                 out_param_in_thousandths,
  output logic                                 out_upload_request
);
  import rcbp_pkg::*;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // result register
  logic out_valid_r;
  dir_t out_dir_r;
  logic out_gear_r;
  frame_res_t out_res_r;

  logic       adv;
  logic       in_accept;
  dir_t       dir_nxt;
  logic       gear_nxt;
  frame_res_t res_nxt;

  // byte moves on when the result slot is empty or being emptied
  assign adv       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign in_accept = in_valid && !in_stall;

  rcbp_drive u_drive (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .rx_byte  (s1_byte_r),
    .dir_nxt  (dir_nxt),
    .gear_nxt (gear_nxt)
  );

  rcbp_frame #(
    .FRAME_MAX (FRAME_MAX)
  ) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .rx_byte (s1_byte_r),
    .res     (res_nxt)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // result register control: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dir_r  <= dir_nxt;
      out_gear_r <= gear_nxt;
      out_res_r  <= res_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_direction            = out_dir_r;
  assign out_high_speed           = out_gear_r;
  assign out_param_write          = out_res_r.write;
  assign out_param_select         = out_res_r.select;
  assign out_param_value          = out_res_r.value;
  assign out_param_in_thousandths = out_res_r.thou;
  assign out_upload_request       = out_res_r.upload;

`ifndef SYNTHESIS
  // a frame end gives a write or an upload request, never both
  a_write_xor_upload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_param_write && out_upload_request))
    else $error("param write and upload request in one beat");

  // thousandths flag only rides on a write
  a_thou_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_param_in_thousandths) |-> out_param_write)
    else $error("thousandths flag without param write");

  // no write: select and value are zero
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_param_write) |-> (out_param_select == 3'd0
                                         && out_param_value == '0))
    else $error("param fields not cleared without write");

  // input register only held back while the result slot is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with free result slot");
`endif

endmodule
